// ===== src/multi_mode_checksum_engine_top_macros.svh =====
// assertion macros used by the checksum engine top level
`ifndef MULTI_MODE_CHECKSUM_ENGINE_TOP_MACROS_SVH
`define MULTI_MODE_CHECKSUM_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MMCE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MMCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mmce_pkg.sv =====
// types, codes and helpers shared by the checksum engine
`default_nettype none

package mmce_pkg;

    typedef enum logic [2:0] {
        MODE_MODBUS = 3'd0,
        MODE_CCITT  = 3'd1,
        MODE_XMODEM = 3'd2,
        MODE_CRC32  = 3'd3,
        MODE_SUM8   = 3'd4,
        MODE_SUM16  = 3'd5,
        MODE_XOR8   = 3'd6,
        MODE_LRC    = 3'd7
    } mode_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CCITT_INITIAL = 2'd1;

    localparam logic [15:0] POLY_MODBUS = 16'hA001;
    localparam logic [15:0] POLY_CCITT  = 16'h1021;
    localparam logic [31:0] POLY_CRC32  = 32'hEDB88320;
    localparam logic [15:0] INIT_MODBUS = 16'hFFFF;
    localparam logic [31:0] INIT_CRC32  = 32'hFFFFFFFF;
    localparam logic [31:0] XOR_CRC32   = 32'hFFFFFFFF;

    // starting accumulator value of a mode
    function automatic logic [31:0] init_for_mode(input mode_t mode,
                                                  input logic [15:0] ccitt_init);
        logic [31:0] init;
        case (mode)
            MODE_MODBUS: init = {16'h0000, INIT_MODBUS};
            MODE_CCITT:  init = {16'h0000, ccitt_init};
            MODE_CRC32:  init = INIT_CRC32;
            default:     init = 32'h0000_0000;
        endcase
        return init;
    endfunction

endpackage

`default_nettype wire

// ===== src/mmce_fold.sv =====
// byte fold and final step of the selected check, one byte per cycle
`default_nettype none

module mmce_fold (
    input  mmce_pkg::mode_t mode,
    input  logic [31:0]     acc,
    input  logic [7:0]      data_byte,
    input  logic            carries_byte,
    output logic [31:0]     acc_folded,
    output logic [31:0]     check_value
);

    logic [15:0] crc16;
    logic [31:0] crc32;
    logic [31:0] fold;

    always_comb begin
        crc16 = 16'h0000;
        crc32 = 32'h0000_0000;
        fold  = acc;
        case (mode)
            mmce_pkg::MODE_MODBUS: begin
                crc16 = acc[15:0] ^ {8'h00, data_byte};
                for (int i = 0; i < 8; i++) begin
                    crc16 = crc16[0] ? ((crc16 >> 1) ^ mmce_pkg::POLY_MODBUS) : (crc16 >> 1);
                end
                fold = {16'h0000, crc16};
            end
            mmce_pkg::MODE_CCITT, mmce_pkg::MODE_XMODEM: begin
                crc16 = acc[15:0] ^ {data_byte, 8'h00};
                for (int i = 0; i < 8; i++) begin
                    crc16 = crc16[15] ? ((crc16 << 1) ^ mmce_pkg::POLY_CCITT) : (crc16 << 1);
                end
                fold = {16'h0000, crc16};
            end
            mmce_pkg::MODE_CRC32: begin
                crc32 = acc ^ {24'h000000, data_byte};
                for (int i = 0; i < 8; i++) begin
                    crc32 = crc32[0] ? ((crc32 >> 1) ^ mmce_pkg::POLY_CRC32) : (crc32 >> 1);
                end
                fold = crc32;
            end
            mmce_pkg::MODE_SUM8, mmce_pkg::MODE_LRC: begin
                fold = {24'h000000, acc[7:0] + data_byte};
            end
            mmce_pkg::MODE_SUM16: begin
                fold = {16'h0000, acc[15:0] + {8'h00, data_byte}};
            end
            default: begin
                fold = {24'h000000, acc[7:0] ^ data_byte};
            end
        endcase
    end

    assign acc_folded = carries_byte ? fold : acc;

    always_comb begin
        case (mode)
            mmce_pkg::MODE_CRC32: check_value = acc_folded ^ mmce_pkg::XOR_CRC32;
            mmce_pkg::MODE_LRC:   check_value = {24'h000000, 8'h00 - acc_folded[7:0]};
            default:              check_value = acc_folded;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/multi_mode_checksum_engine_top.sv =====
// top level of the multi-mode checksum engine
// usage:
//   s_ channel carries one message byte per item (s_data_byte), a flag that
//   the byte belongs to the message (s_carries_byte) and an end-of-message
//   flag (s_last_byte). an item with no byte and last set closes a message
//   without adding anything
//   m_ channel carries one check value per message, zero-extended to 32 bits
//   cfg port selects the check (index 0) and the ccitt start value (index 1);
//   a write to index 0 or 1 re-arms the accumulator, so write only while idle
// path: an item is registered in the input register and folded from there;
//   a last item's check is written to the output register as the item leaves
//   the input register, and m_valid is driven from that output register
// throughput: one item per cycle unless a last item waits; the eight crc bit
//   steps are unrolled, so the accumulator loop holds just one register
// stall: while the output register holds an untaken check, bytes that do
//   not end a message still flow; a second last item waits in the input
//   register and s_ready drops until m_ready takes the pending check
// reset: synchronous active-low aresetn selects modbus, ccitt start ffff
//   and loads the accumulator with ffff; both channels come up empty
`default_nettype none

`include "multi_mode_checksum_engine_top_macros.svh"

module multi_mode_checksum_engine_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [mmce_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mmce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input byte channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_data_byte,
    input  wire logic                              s_carries_byte,
    input  wire logic                              s_last_byte,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [31:0]                            m_check_value
);

    // configuration registers
    mmce_pkg::mode_t mode_reg, mode_next;
    logic [15:0]     ccitt_reg, ccitt_next;

    // input register stage
    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_data_reg;
    logic        in_carries_reg;
    logic        in_last_reg;

    // accumulator and output register
    logic [31:0] running_check_reg, running_check_next;
    logic        out_vld_reg, out_vld_next;
    logic [31:0] out_check_reg;

    logic [31:0] acc_folded;
    logic [31:0] check_value;
    logic [31:0] init_value;
    logic        advance;
    logic        fire;
    logic        s_accept;
    logic        cfg_hit;

    // a last item may only leave the input register when the output slot frees
    assign advance  = !(in_last_reg && out_vld_reg && !m_ready);
    assign fire     = in_vld_reg && advance;
    assign s_ready  = !in_vld_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign cfg_hit = cfg_wr_en && ((cfg_index == mmce_pkg::CFG_CHECK_MODE) ||
                                   (cfg_index == mmce_pkg::CFG_CCITT_INITIAL));

    // config write: new register values feed the re-arm value directly
    always_comb begin
        mode_next  = mode_reg;
        ccitt_next = ccitt_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mmce_pkg::CFG_CHECK_MODE:    mode_next  = mmce_pkg::mode_t'(cfg_wdata[2:0]);
                mmce_pkg::CFG_CCITT_INITIAL: ccitt_next = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign init_value = mmce_pkg::init_for_mode(mode_next, ccitt_next);

    mmce_fold u_fold (
        .mode         (mode_reg),
        .acc          (running_check_reg),
        .data_byte    (in_data_reg),
        .carries_byte (in_carries_reg),
        .acc_folded   (acc_folded),
        .check_value  (check_value)
    );

    always_comb begin
        running_check_next = running_check_reg;
        if (cfg_hit) begin
            running_check_next = init_value;
        end else if (fire) begin
            // re-arm on the end of a message, else keep folding
            running_check_next = in_last_reg ? init_value : acc_folded;
        end
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    assign out_vld_next = (out_vld_reg && !m_ready) || (fire && in_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= mmce_pkg::MODE_MODBUS;
            ccitt_reg         <= 16'hFFFF;
            running_check_reg <= {16'h0000, mmce_pkg::INIT_MODBUS};
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
        end else begin
            mode_reg          <= mode_next;
            ccitt_reg         <= ccitt_next;
            running_check_reg <= running_check_next;
            in_vld_reg        <= in_vld_next;
            out_vld_reg       <= out_vld_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg    <= s_data_byte;
            in_carries_reg <= s_carries_byte;
            in_last_reg    <= s_last_byte;
        end
        if (fire && in_last_reg) begin
            out_check_reg <= check_value;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_check_value = out_check_reg;

    // a pending last item must hold off new input while the check is unread
    `MMCE_ASSERT_IMPLY(a_last_blocks_input, aclk, aresetn,
        in_vld_reg && in_last_reg && out_vld_reg && !m_ready, !s_ready,
        "last item left input stage while output slot was full")

    // a write to index 0 or 1 re-arms the accumulator to the mode's start value
    `MMCE_ASSERT_NEXT(a_cfg_rearms, aclk, aresetn,
        cfg_hit,
        running_check_reg == mmce_pkg::init_for_mode(mode_reg, ccitt_reg),
        "accumulator not re-armed after config write")

    // a new check appears only after a last item left the input stage
    `MMCE_ASSERT_IMPLY(a_result_from_last, aclk, aresetn,
        $rose(out_vld_reg), $past(in_vld_reg && in_last_reg),
        "check emitted without a last item")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the checksum engine: directed and random messages checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import mmce_pkg::*;

    // register indexes past the end of the list, writes there are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    // cycles the block may still be busy after the last check has landed
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       carries;
        logic       last;
    } byte_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_carries_byte = 1'b0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_check_value;

    // stimulus and scoreboard state
    byte_item_t  pending_items[$];
    logic [31:0] expected_checks[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          errors = 0;
    int          items_taken = 0;
    int          checks_matched = 0;
    int          reg_writes = 0;
    int          checks_per_mode[8];

    // predictor copy of the block's registers and accumulator
    mode_t       pred_mode;
    logic [15:0] pred_ccitt_init;
    logic [31:0] pred_acc;

    multi_mode_checksum_engine_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_carries_byte (s_carries_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_check_value  (m_check_value)
    );

    always #5 aclk = ~aclk;

    // accumulator value a mode starts each message from
    function automatic logic [31:0] arm_value(input mode_t mode, input logic [15:0] ccitt_init);
        case (mode)
            MODE_MODBUS: return {16'h0000, INIT_MODBUS};
            MODE_CCITT:  return {16'h0000, ccitt_init};
            MODE_CRC32:  return INIT_CRC32;
            default:     return 32'h0000_0000;
        endcase
    endfunction

    // fold one message byte into the running check, crcs one bit per step
    function automatic logic [31:0] absorb_byte(input mode_t mode, input logic [31:0] acc,
                                                input logic [7:0] b);
        logic [15:0] reg16;
        logic [31:0] reg32;
        reg16 = acc[15:0];
        reg32 = acc;
        case (mode)
            MODE_MODBUS: begin
                reg16 = reg16 ^ {8'h00, b};
                for (int i = 0; i < 8; i++)
                    reg16 = reg16[0] ? ((reg16 >> 1) ^ POLY_MODBUS) : (reg16 >> 1);
                return {16'h0000, reg16};
            end
            MODE_CCITT, MODE_XMODEM: begin
                reg16 = reg16 ^ {b, 8'h00};
                for (int i = 0; i < 8; i++)
                    reg16 = reg16[15] ? ((reg16 << 1) ^ POLY_CCITT) : (reg16 << 1);
                return {16'h0000, reg16};
            end
            MODE_CRC32: begin
                reg32 = reg32 ^ {24'h000000, b};
                for (int i = 0; i < 8; i++)
                    reg32 = reg32[0] ? ((reg32 >> 1) ^ POLY_CRC32) : (reg32 >> 1);
                return reg32;
            end
            MODE_SUM8, MODE_LRC: return {24'h000000, acc[7:0] + b};
            MODE_SUM16:          return {16'h0000, acc[15:0] + {8'h00, b}};
            default:             return {24'h000000, acc[7:0] ^ b};
        endcase
    endfunction

    // value emitted when a message closes
    function automatic logic [31:0] close_value(input mode_t mode, input logic [31:0] acc);
        case (mode)
            MODE_CRC32: return acc ^ XOR_CRC32;
            MODE_LRC:   return {24'h000000, 8'h00 - acc[7:0]};
            default:    return acc;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s, got %08h expected %08h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic push_item(input logic [7:0] data, input logic carries, input logic last);
        byte_item_t it;
        it.data = data;
        it.carries = carries;
        it.last = last;
        pending_items.push_back(it);
    endtask

    // one register write, enable high for a single edge
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
    endtask

    // block until every item is taken, every check seen, then let the pipe drain
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_checks.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver: next item goes out once the current one is taken, with random gaps
    always @(posedge aclk) begin : drive_items
        byte_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= it.data;
                s_carries_byte <= it.carries;
                s_last_byte <= it.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: checks results first, then tracks register writes and taken items
    always @(posedge aclk) begin : watch
        logic [31:0] want;
        if (!aresetn) begin
            pred_mode = MODE_MODBUS;
            pred_ccitt_init = 16'hFFFF;
            pred_acc = arm_value(MODE_MODBUS, 16'hFFFF);
        end else begin
            if (m_valid && m_ready) begin
                if (expected_checks.size() == 0) begin
                    report_mismatch("check with no message closed", m_check_value, 32'h0);
                end else begin
                    want = expected_checks.pop_front();
                    if (m_check_value !== want)
                        report_mismatch("check_value", m_check_value, want);
                    else
                        checks_matched++;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CHECK_MODE: begin
                        pred_mode = mode_t'(cfg_wdata[2:0]);
                        pred_acc = arm_value(pred_mode, pred_ccitt_init);
                    end
                    CFG_CCITT_INITIAL: begin
                        pred_ccitt_init = cfg_wdata[15:0];
                        pred_acc = arm_value(pred_mode, pred_ccitt_init);
                    end
                    default: ; // spare index, no effect at all
                endcase
            end
            if (s_valid && s_ready) begin
                items_taken++;
                if (s_carries_byte)
                    pred_acc = absorb_byte(pred_mode, pred_acc, s_data_byte);
                if (s_last_byte) begin
                    expected_checks.push_back(close_value(pred_mode, pred_acc));
                    checks_per_mode[pred_mode]++;
                    pred_acc = arm_value(pred_mode, pred_ccitt_init);
                end
            end
        end
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        int          counted;
        int          len;
        mode_t       cur_mode;
        logic [15:0] start;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: modbus straight out of reset, extremes of the byte
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        // empty close right after a close, then an idle item inside a message
        push_item(8'hA5, 1'b0, 1'b1);
        push_item(8'hAA, 1'b0, 1'b0);
        push_item(8'h55, 1'b1, 1'b1);
        wait_idle();

        // a register write in mid-message drops the bytes gathered so far
        push_item(8'h12, 1'b1, 1'b0);
        wait_idle();
        cfg_write(CFG_CCITT_INITIAL, 16'h1D0F);
        push_item(8'h34, 1'b1, 1'b1);
        wait_idle();

        // a write to a spare index keeps the message going
        push_item(8'h56, 1'b1, 1'b0);
        wait_idle();
        cfg_write(CFG_SPARE_LO, 16'hFFFF);
        push_item(8'h78, 1'b1, 1'b1);
        wait_idle();

        // every other check mode once
        for (int m = MODE_CCITT; m <= MODE_LRC; m++) begin
            cur_mode = mode_t'(m);
            cfg_write(CFG_CHECK_MODE, {13'd0, cur_mode});
            push_item(8'hFF, 1'b1, 1'b0);
            push_item(8'h80, 1'b1, 1'b1);
            wait_idle();
        end

        // random phases: each mode twice, pacing rotates through four profiles
        for (int phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            case (phase)
                0, 9:    start = 16'h0000;
                1, 8:    start = 16'hFFFF;
                default: start = 16'($urandom_range(16'hFFFF));
            endcase
            cur_mode = mode_t'(phase % 8);
            // order of the two writes varies, spare index hit now and then
            if (phase[0]) begin
                cfg_write(CFG_CCITT_INITIAL, start);
                cfg_write(CFG_CHECK_MODE, {13'd0, cur_mode});
                cfg_write(CFG_SPARE_HI, 16'($urandom_range(16'hFFFF)));
            end else begin
                cfg_write(CFG_CHECK_MODE, {13'd0, cur_mode});
                cfg_write(CFG_CCITT_INITIAL, start);
            end

            counted = 0;
            while (counted < 24) begin
                // mostly short messages, an occasional long one
                len = ($urandom_range(7) == 0) ? $urandom_range(20, 8) : $urandom_range(5);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(5) == 0)
                        push_item(8'($urandom_range(255)), 1'b0, 1'b0);
                    push_item(8'($urandom_range(255)), 1'b1, 1'b0);
                    counted++;
                end
                // closing item: usually carries a byte, sometimes an empty close
                push_item(8'($urandom_range(255)), ($urandom_range(3) != 0), 1'b1);
                counted++;
            end
            wait_idle();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (20) @(posedge aclk);

        $display("testbench: %0d items taken, %0d checks matched, %0d register writes",
                 items_taken, checks_matched, reg_writes);
        $display("testbench: checks per mode modbus %0d ccitt %0d xmodem %0d crc32 %0d",
                 checks_per_mode[MODE_MODBUS], checks_per_mode[MODE_CCITT],
                 checks_per_mode[MODE_XMODEM], checks_per_mode[MODE_CRC32]);
        $display("testbench: checks per mode sum8 %0d sum16 %0d xor8 %0d lrc %0d",
                 checks_per_mode[MODE_SUM8], checks_per_mode[MODE_SUM16],
                 checks_per_mode[MODE_XOR8], checks_per_mode[MODE_LRC]);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/mmce_pkg.sv
src/mmce_fold.sv
src/multi_mode_checksum_engine_top.sv
tb/testbench.sv
